FILE: rtl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants of the WebSocket frame deframer: event codes,
// header field codes and the record passed from the parser to the output side.
// ----------------------------------------------------------------------------
package wsd_pkg;

  // Event codes on the result channel
  typedef enum logic [1:0] {
    EV_DATA      = 2'd0,
    EV_EMPTY_END = 2'd1,
    EV_CLOSE     = 2'd2,
    EV_TOO_LONG  = 2'd3
  } ev_kind_t;

  // Header codes
  localparam logic [3:0] OPC_CLOSE    = 4'h8;
  localparam logic [6:0] LEN7_EXT16   = 7'd126;
  localparam logic [6:0] LEN7_EXT64   = 7'd127;

  // Config reset value
  localparam logic [31:0] MAX_LEN_RESET = 32'd2048;

  // Depth of the queue between parser and output side (power of two)
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // One classified event: raw byte plus the key byte that unmasks it
  typedef struct packed {
    ev_kind_t    kind;
    logic [7:0]  data;
    logic [7:0]  key;
    logic [3:0]  opcode;
    logic        last;
  } rec_t;

endpackage

FILE: rtl/wsd_front.sv
// ----------------------------------------------------------------------------
// wsd_front
// Frame parser. Takes one byte per take cycle, tracks the header, extended
// length and mask key, and classifies each byte into at most one event record.
// ----------------------------------------------------------------------------
module wsd_front #(
  parameter int LENGTH_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic [7:0]         rx_byte,
  input  logic               cfg_wr,
  input  logic [31:0]        cfg_max,
  output logic               rec_push,
  output wsd_pkg::rec_t      rec
);

  localparam int CW = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_EXT16, PH_EXT64, PH_MASK, PH_PAYLOAD
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic                   halted_r, halted_nxt;
  logic                   frag_r, frag_nxt;
  logic [3:0]             fopc_r, fopc_nxt;
  logic                   fin_r, fin_nxt;
  logic [3:0]             opc_r, opc_nxt;
  logic                   masked_r, masked_nxt;
  logic [2:0]             cnt_r, cnt_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic [1:0]             pos_r, pos_nxt;
  logic [31:0]            key_r, key_nxt;
  logic [31:0]            max_r, max_nxt;

  logic [LENGTH_BITS-1:0] len_now;
  logic                   len_done;
  logic                   pay_start;
  logic                   frame_end;
  logic                   masked_now;
  logic                   frag_now;
  logic [3:0]             fopc_now;
  logic [3:0]             msg_opc;
  logic [7:0]             key_sel;
  logic                   emit;

  // Key byte for the current payload position, first key byte first
  always_comb begin
    case (pos_r)
      2'd0:    key_sel = key_r[31:24];
      2'd1:    key_sel = key_r[23:16];
      2'd2:    key_sel = key_r[15:8];
      default: key_sel = key_r[7:0];
    endcase
  end

  // Parser next state and event record
  always_comb begin
    phase_nxt  = phase_r;
    halted_nxt = halted_r;
    fopc_nxt   = fopc_r;
    fin_nxt    = fin_r;
    opc_nxt    = opc_r;
    masked_nxt = masked_r;
    cnt_nxt    = cnt_r;
    len_nxt    = len_r;
    rem_nxt    = rem_r;
    pos_nxt    = pos_r;
    key_nxt    = key_r;
    max_nxt    = cfg_wr ? cfg_max : max_r;
    len_now    = len_r;
    len_done   = 1'b0;
    pay_start  = 1'b0;
    frame_end  = 1'b0;
    masked_now = masked_r;
    frag_now   = frag_r;
    fopc_now   = fopc_r;
    emit       = 1'b0;
    rec        = '0;

    if (take && !halted_r) begin
      case (phase_r)
        PH_HDR0: begin
          fin_nxt   = rx_byte[7];
          opc_nxt   = rx_byte[3:0];
          phase_nxt = PH_HDR1;
        end
        PH_HDR1: begin
          masked_nxt = rx_byte[7];
          masked_now = rx_byte[7];
          if (opc_r == wsd_pkg::OPC_CLOSE) begin
            halted_nxt = 1'b1;
            emit       = 1'b1;
            rec.kind   = wsd_pkg::EV_CLOSE;
          end else begin
            // first non-final frame opens a fragmented message
            if (!fin_r && !frag_r) begin
              frag_now = 1'b1;
              fopc_now = opc_r;
            end
            cnt_nxt = 3'd0;
            len_nxt = '0;
            if (rx_byte[6:0] == wsd_pkg::LEN7_EXT16) begin
              phase_nxt = PH_EXT16;
            end else if (rx_byte[6:0] == wsd_pkg::LEN7_EXT64) begin
              phase_nxt = PH_EXT64;
            end else begin
              len_now  = LENGTH_BITS'(rx_byte[6:0]);
              len_done = 1'b1;
            end
          end
        end
        PH_EXT16, PH_EXT64: begin
          // big-endian shift-in, upper bytes fall off the top
          len_now = {len_r[LENGTH_BITS-9:0], rx_byte};
          len_nxt = len_now;
          cnt_nxt = cnt_r + 3'd1;
          if ((phase_r == PH_EXT16 && cnt_r == 3'd1) ||
              (phase_r == PH_EXT64 && cnt_r == 3'd7)) begin
            len_done = 1'b1;
          end
        end
        PH_MASK: begin
          key_nxt = {key_r[23:0], rx_byte};
          cnt_nxt = cnt_r + 3'd1;
          if (cnt_r == 3'd3) begin
            pay_start = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          emit     = 1'b1;
          rec.kind = wsd_pkg::EV_DATA;
          rec.data = rx_byte;
          rec.key  = masked_r ? key_sel : 8'h00;
          rec.last = (rem_r == LENGTH_BITS'(1)) && fin_r;
          rem_nxt  = rem_r - LENGTH_BITS'(1);
          pos_nxt  = pos_r + 2'd1;
          if (rem_r == LENGTH_BITS'(1)) begin
            frame_end = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_HDR0;
        end
      endcase

      // Length known: limit check, then key or payload
      if (len_done) begin
        len_nxt = len_now;
        if (CW'(len_now) > CW'(max_r)) begin
          halted_nxt = 1'b1;
          emit       = 1'b1;
          rec.kind   = wsd_pkg::EV_TOO_LONG;
        end else if (masked_now) begin
          cnt_nxt   = 3'd0;
          phase_nxt = PH_MASK;
        end else begin
          pay_start = 1'b1;
        end
      end

      // Key known or absent: start payload, or close out an empty frame
      if (pay_start) begin
        pos_nxt = 2'd0;
        rem_nxt = len_now;
        if (len_now == '0) begin
          frame_end = 1'b1;
          if (fin_r) begin
            emit     = 1'b1;
            rec.kind = wsd_pkg::EV_EMPTY_END;
            rec.last = 1'b1;
          end
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
    end

    // Opcode is taken before a final frame closes the message
    msg_opc    = frag_now ? fopc_now : opc_r;
    rec.opcode = (rec.kind == wsd_pkg::EV_CLOSE) ? opc_r : msg_opc;
    fopc_nxt   = fopc_now;
    frag_nxt   = (frame_end && fin_r) ? 1'b0 : frag_now;
    if (frame_end) begin
      phase_nxt = PH_HDR0;
    end
  end

  assign rec_push = emit;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      halted_r <= 1'b0;
      frag_r   <= 1'b0;
      max_r    <= wsd_pkg::MAX_LEN_RESET;
    end else begin
      phase_r  <= phase_nxt;
      halted_r <= halted_nxt;
      frag_r   <= frag_nxt;
      max_r    <= max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fopc_r   <= fopc_nxt;
    fin_r    <= fin_nxt;
    opc_r    <= opc_nxt;
    masked_r <= masked_nxt;
    cnt_r    <= cnt_nxt;
    len_r    <= len_nxt;
    rem_r    <= rem_nxt;
    pos_r    <= pos_nxt;
    key_r    <= key_nxt;
  end

  // Once halted, nothing more is queued
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> !rec_push)
    else $error("event produced while halted");

  // Close and too-long events halt the parser
  a_halt_after: assert property (@(posedge clk) disable iff (!rst_n)
    rec_push && (rec.kind == wsd_pkg::EV_CLOSE || rec.kind == wsd_pkg::EV_TOO_LONG)
    |=> halted_r)
    else $error("terminal event without halt");

  // Payload phase always has bytes left
  a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (rem_r != '0))
    else $error("payload phase with no bytes left");

endmodule

FILE: rtl/wsd_fifo.sv
// ----------------------------------------------------------------------------
// wsd_fifo
// Short event queue between the parser and the output stage, so that either
// side can stall without stopping the other.
// ----------------------------------------------------------------------------
module wsd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  wsd_pkg::rec_t     wdata,
  input  logic              pop,
  output wsd_pkg::rec_t     rdata,
  output logic              full,
  output logic              empty
);

  localparam int AW = wsd_pkg::QAW;

  wsd_pkg::rec_t            mem_r [wsd_pkg::QDEPTH];
  logic [wsd_pkg::QAW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [wsd_pkg::QAW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [wsd_pkg::QAW:0]    cnt_r, cnt_nxt;
  logic                     do_push;
  logic                     do_pop;

  assign full    = (cnt_r == (wsd_pkg::QAW+1)'(wsd_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // The parser only pushes when a slot is free
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

  // Fill count stays within depth
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (wsd_pkg::QAW+1)'(wsd_pkg::QDEPTH))
    else $error("queue count out of range");

endmodule

FILE: rtl/wsd_back.sv
// ----------------------------------------------------------------------------
// wsd_back
// Output stage. Pulls event records from the queue, unmasks payload bytes and
// holds the result in an output register until it is popped.
// ----------------------------------------------------------------------------
module wsd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  wsd_pkg::rec_t     q_rec,
  input  logic              q_empty,
  output logic              q_pop,
  input  logic              out_pop,
  output logic              out_empty,
  output logic [1:0]        out_event_kind,
  output logic [7:0]        out_payload_byte,
  output logic [3:0]        out_message_opcode,
  output logic              out_message_last
);

  logic               valid_r, valid_nxt;
  wsd_pkg::ev_kind_t  kind_r;
  logic [7:0]         byte_r;
  logic [3:0]         opc_r;
  logic               last_r;

  // Refill the output register when it is free or being taken
  assign q_pop     = !q_empty && (!valid_r || out_pop);
  assign valid_nxt = q_pop ? 1'b1 : (out_pop ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Result payload, unmasked on load
  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r <= q_rec.kind;
      byte_r <= q_rec.data ^ q_rec.key;
      opc_r  <= q_rec.opcode;
      last_r <= q_rec.last;
    end
  end

  assign out_empty          = !valid_r;
  assign out_event_kind     = kind_r;
  assign out_payload_byte   = byte_r;
  assign out_message_opcode = opc_r;
  assign out_message_last   = last_r;

endmodule

FILE: rtl/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Parses WebSocket frames from a byte stream and delivers unmasked payload
// bytes and message events through a queue-style result port.
//
//  Channel | Ports                               | Transaction when
//  --------+-------------------------------------+---------------------------
//  input   | in_push, in_full, in_rx_byte        | in_push && !in_full
//  result  | out_pop, out_empty, out_event_kind, | out_pop && !out_empty
//          | out_payload_byte,                   |
//          | out_message_opcode, out_message_last|
//  config  | cfg_valid, cfg_ready,               | cfg_valid && cfg_ready
//          | cfg_max_frame_length                |
//
// One byte is accepted per cycle while in_full is low; the parser decides
// each byte in the cycle it arrives. The queue is written at the accepting
// edge; the output register loads from the queue when free or being popped.
// Reset is synchronous; it clears the parser, the queue and the output
// register, and sets the frame length limit to 2048. cfg_ready is always high.
// in_full follows the event queue only; when the result side stalls the queue
// fills after four events beyond the one held at the output. Once halted,
// bytes are still taken and dropped until reset.
// ----------------------------------------------------------------------------
module websocket_frame_deframer #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [1:0]  out_event_kind,
  output logic [7:0]  out_payload_byte,
  output logic [3:0]  out_message_opcode,
  output logic        out_message_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_max_frame_length
);

  wsd_pkg::rec_t  f_rec;
  logic           f_push;
  wsd_pkg::rec_t  q_rec;
  logic           q_pop;
  logic           q_empty;
  logic           q_full;
  logic           take;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign take      = in_push && !q_full;

  // Front: header parsing and classification
  wsd_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .rx_byte  (in_rx_byte),
    .cfg_wr   (cfg_valid && cfg_ready),
    .cfg_max  (cfg_max_frame_length),
    .rec_push (f_push),
    .rec      (f_rec)
  );

  // Event queue
  wsd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata (f_rec),
    .pop   (q_pop),
    .rdata (q_rec),
    .full  (q_full),
    .empty (q_empty)
  );

  // Back: unmasking and output register
  wsd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_rec              (q_rec),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .out_pop            (out_pop),
    .out_empty          (out_empty),
    .out_event_kind     (out_event_kind),
    .out_payload_byte   (out_payload_byte),
    .out_message_opcode (out_message_opcode),
    .out_message_last   (out_message_last)
  );

endmodule

FILE: tb/websocket_frame_deframer_tb.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_tb
// Self-checking bench for the WebSocket frame deframer. Byte streams of whole
// frames are pushed in, and a behavioral deframer built into the bench
// predicts each event. A checker compares every popped result field by field
// against the oldest prediction. Directed frames cover short, extended, empty,
// masked and fragmented cases plus the length limit. Random traffic then runs
// under four flow-control mixes. The run ends with one halting frame, which is
// either a close or an oversized frame, followed by bytes that must be dropped.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_tb;

  // Opcodes used by the bench
  localparam logic [3:0] OPC_CONT   = 4'h0;
  localparam logic [3:0] OPC_TEXT   = 4'h1;
  localparam logic [3:0] OPC_BINARY = 4'h2;
  localparam logic [3:0] OPC_PING   = 4'h9;

  // Length encodings on the wire
  localparam int FORM_SHORT = 0;
  localparam int FORM_EXT16 = 1;
  localparam int FORM_EXT64 = 2;

  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES   = 380;

  // Parser phases of the bench's deframer
  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_EXT16, PH_EXT64, PH_KEY, PH_BODY
  } parse_phase_t;

  typedef struct packed {
    wsd_pkg::ev_kind_t kind;
    logic [7:0]        data;
    logic [3:0]        opcode;
    logic              last;
  } deframed_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_pop = 1'b0;
  logic        out_empty;
  logic [1:0]  out_event_kind;
  logic [7:0]  out_payload_byte;
  logic [3:0]  out_message_opcode;
  logic        out_message_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_max_frame_length = 32'd0;

  // Deframer state mirrored by the bench
  logic [31:0]  limit_m;
  parse_phase_t phase_m;
  logic         fin_m;
  logic [3:0]   opc_m;
  logic         masked_m;
  int           field_cnt_m;
  logic [31:0]  len_m;
  logic [31:0]  pos_m;
  logic [31:0]  key_m;
  logic         frag_m;
  logic [3:0]   frag_opc_m;
  logic         halted_m;

  deframed_t pending_events[$];
  deframed_t want;

  int    send_idle_pct  = 0;
  int    recv_stall_pct = 0;
  int    error_count    = 0;
  int    bytes_sent     = 0;
  int    frames_sent    = 0;
  int    results_seen   = 0;
  int    idle_cycles    = 0;
  string halt_desc      = "none";

  websocket_frame_deframer u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_rx_byte           (in_rx_byte),
    .out_pop              (out_pop),
    .out_empty            (out_empty),
    .out_event_kind       (out_event_kind),
    .out_payload_byte     (out_payload_byte),
    .out_message_opcode   (out_message_opcode),
    .out_message_last     (out_message_last),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_max_frame_length (cfg_max_frame_length)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Deframer prediction
  // --------------------------------------------------------------------------
  function automatic void clear_deframer();
    limit_m     = wsd_pkg::MAX_LEN_RESET;
    phase_m     = PH_HDR0;
    fin_m       = 1'b0;
    opc_m       = OPC_CONT;
    masked_m    = 1'b0;
    field_cnt_m = 0;
    len_m       = '0;
    pos_m       = '0;
    key_m       = '0;
    frag_m      = 1'b0;
    frag_opc_m  = OPC_CONT;
    halted_m    = 1'b0;
  endfunction

  function automatic void add_event(wsd_pkg::ev_kind_t kind, logic [7:0] data,
                                    logic [3:0] opc, logic last);
    deframed_t ev;
    ev.kind   = kind;
    ev.data   = data;
    ev.opcode = opc;
    ev.last   = last;
    pending_events.push_back(ev);
  endfunction

  // Fragmented messages report the opcode of their first frame
  function automatic logic [3:0] message_opc();
    return frag_m ? frag_opc_m : opc_m;
  endfunction

  function automatic void close_frame();
    if (fin_m) frag_m = 1'b0;
    phase_m = PH_HDR0;
  endfunction

  // Key known or absent: enter the body, or finish an empty frame
  function automatic void open_body();
    pos_m = '0;
    if (len_m == 0) begin
      if (fin_m) add_event(wsd_pkg::EV_EMPTY_END, 8'h00, message_opc(), 1'b1);
      close_frame();
    end else begin
      phase_m = PH_BODY;
    end
  endfunction

  function automatic void length_done();
    if (len_m > limit_m) begin
      halted_m = 1'b1;
      add_event(wsd_pkg::EV_TOO_LONG, 8'h00, message_opc(), 1'b0);
    end else if (masked_m) begin
      field_cnt_m = 0;
      phase_m = PH_KEY;
    end else begin
      open_body();
    end
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    logic [7:0] v;
    logic       at_end;
    logic [3:0] opc;
    if (halted_m) return;
    case (phase_m)
      PH_HDR0: begin
        fin_m   = b[7];
        opc_m   = b[3:0];
        phase_m = PH_HDR1;
      end
      PH_HDR1: begin
        masked_m = b[7];
        if (opc_m == wsd_pkg::OPC_CLOSE) begin
          halted_m = 1'b1;
          add_event(wsd_pkg::EV_CLOSE, 8'h00, opc_m, 1'b0);
        end else begin
          if (!fin_m && !frag_m) begin
            frag_m     = 1'b1;
            frag_opc_m = opc_m;
          end
          len_m = '0;
          field_cnt_m = 0;
          if (b[6:0] == wsd_pkg::LEN7_EXT16) phase_m = PH_EXT16;
          else if (b[6:0] == wsd_pkg::LEN7_EXT64) phase_m = PH_EXT64;
          else begin
            len_m = {25'd0, b[6:0]};
            length_done();
          end
        end
      end
      PH_EXT16, PH_EXT64: begin
        // only the low 32 bits of the extended length survive
        len_m = {len_m[23:0], b};
        field_cnt_m++;
        if (field_cnt_m == ((phase_m == PH_EXT16) ? 2 : 8)) length_done();
      end
      PH_KEY: begin
        key_m = {key_m[23:0], b};
        field_cnt_m++;
        if (field_cnt_m == 4) open_body();
      end
      PH_BODY: begin
        v = b;
        if (masked_m) v = v ^ 8'(key_m >> (24 - 8 * pos_m[1:0]));
        pos_m  = pos_m + 1;
        at_end = (pos_m >= len_m);
        opc    = message_opc();
        if (at_end) begin
          add_event(wsd_pkg::EV_DATA, v, opc, fin_m);
          close_frame();
        end else begin
          add_event(wsd_pkg::EV_DATA, v, opc, 1'b0);
        end
      end
      default: phase_m = PH_HDR0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random pop, checker, watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_pop <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      results_seen++;
      if (pending_events.size() == 0) begin
        $error("unexpected result: kind %0d byte %02h opcode %0h last %0b",
               out_event_kind, out_payload_byte, out_message_opcode, out_message_last);
        error_count++;
      end else begin
        want = pending_events.pop_front();
        if (out_event_kind !== want.kind) begin
          $error("event_kind: expected %0d, got %0d", want.kind, out_event_kind);
          error_count++;
        end
        if (out_payload_byte !== want.data) begin
          $error("payload_byte: expected %02h, got %02h", want.data, out_payload_byte);
          error_count++;
        end
        if (out_message_opcode !== want.opcode) begin
          $error("message_opcode: expected %0h, got %0h", want.opcode, out_message_opcode);
          error_count++;
        end
        if (out_message_last !== want.last) begin
          $error("message_last: expected %0b, got %0b", want.last, out_message_last);
          error_count++;
        end
      end
    end
  end

  // Ends the run when no transaction of any kind happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: %0d cycles without a transaction", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // One byte transaction, followed by a random sender gap
  task automatic push_byte(input logic [7:0] b);
    in_push    <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    deframe_byte(b);
    bytes_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Stop sending, let all predicted results drain, then let the pipe settle
  task automatic drain();
    in_push <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] value);
    drain();
    cfg_valid            <= 1'b1;
    cfg_max_frame_length <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    limit_m = value;
    cfg_valid <= 1'b0;
  endtask

  // Header, optional extended length, then optional key and body when with_body
  task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] opc,
                            input logic masked, input logic [31:0] len, input int form,
                            input logic [31:0] len_hi, input logic [31:0] key,
                            input bit with_body);
    logic [6:0] len7;
    len7 = (form == FORM_SHORT) ? len[6:0] :
           (form == FORM_EXT16) ? wsd_pkg::LEN7_EXT16 : wsd_pkg::LEN7_EXT64;
    frames_sent++;
    push_byte({fin, rsv, opc});
    push_byte({masked, len7});
    if (form == FORM_EXT16) begin
      push_byte(len[15:8]);
      push_byte(len[7:0]);
    end else if (form == FORM_EXT64) begin
      for (int i = 3; i >= 0; i--) push_byte(len_hi[8*i +: 8]);
      for (int i = 3; i >= 0; i--) push_byte(len[8*i +: 8]);
    end
    if (!with_body) return;
    if (masked)
      for (int i = 3; i >= 0; i--) push_byte(key[8*i +: 8]);
    for (int i = 0; i < len; i++) push_byte($urandom_range(255));
  endtask

  // Plain frame with a short length and a random key
  task automatic send_simple(input logic fin, input logic [3:0] opc, input logic masked,
                             input int len);
    send_frame(fin, 3'b000, opc, masked, len, FORM_SHORT, '0, $urandom, 1'b1);
  endtask

  function automatic logic [3:0] random_opc();
    logic [3:0] opc;
    opc = $urandom_range(15);
    while (opc == wsd_pkg::OPC_CLOSE) opc = $urandom_range(15);
    return opc;
  endfunction

  // Mostly short bodies, a few long ones, never above the current limit
  function automatic logic [31:0] random_len();
    int          r;
    logic [31:0] n;
    r = $urandom_range(99);
    if (r < 65) n = $urandom_range(12);
    else if (r < 92) n = $urandom_range(13, 40);
    else n = $urandom_range(126, 300);
    if (n > limit_m) n = $urandom_range(limit_m);
    return n;
  endfunction

  // One message of one to four frames with random content
  task automatic send_random_message();
    int          nfrag;
    int          form;
    int          r;
    logic [31:0] len;
    logic [3:0]  opc;
    nfrag = ($urandom_range(3) == 0) ? $urandom_range(2, 4) : 1;
    for (int i = 0; i < nfrag; i++) begin
      opc = (i == 0 || $urandom_range(4) == 0) ? random_opc() : OPC_CONT;
      len = random_len();
      r = $urandom_range(99);
      if (len < 126) form = (r < 75) ? FORM_SHORT : (r < 90) ? FORM_EXT16 : FORM_EXT64;
      else form = (r < 50) ? FORM_EXT16 : FORM_EXT64;
      send_frame(i == nfrag - 1, ($urandom_range(9) == 0) ? 3'($urandom) : 3'b000, opc,
                 1'($urandom), len, form, $urandom_range(1) ? $urandom : 32'd0, $urandom,
                 1'b1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Unmasked and masked frames, byte extremes through the key XOR
  task automatic test_single_frames();
    send_frame(1'b1, 3'b000, OPC_TEXT, 1'b0, 2, FORM_SHORT, '0, '0, 1'b1);
    send_frame(1'b1, 3'b111, OPC_BINARY, 1'b1, 5, FORM_SHORT, '0, 32'hFFFF_0000, 1'b1);
    send_frame(1'b1, 3'b000, 4'hF, 1'b1, 4, FORM_SHORT, '0, 32'h0000_FFFF, 1'b1);
  endtask

  // Final empty frames give an end event, non-final ones give nothing
  task automatic test_empty_frames();
    send_simple(1'b1, OPC_TEXT, 1'b0, 0);
    send_simple(1'b1, OPC_PING, 1'b1, 0);
    send_simple(1'b0, OPC_BINARY, 1'b0, 0);
    send_simple(1'b1, OPC_CONT, 1'b1, 0);
  endtask

  // 16-bit and 64-bit lengths, upper half of the 64-bit length dropped
  task automatic test_extended_lengths();
    send_frame(1'b1, 3'b000, OPC_TEXT, 1'b0, 2, FORM_EXT16, '0, '0, 1'b1);
    send_frame(1'b1, 3'b000, OPC_BINARY, 1'b1, 3, FORM_EXT64, 32'hFFFF_FFFF, $urandom, 1'b1);
    send_frame(1'b1, 3'b000, OPC_BINARY, 1'b0, 126, FORM_EXT16, '0, '0, 1'b1);
  endtask

  // First opcode kept across fragments, stray continuation acts as opcode 0
  task automatic test_fragmented_messages();
    send_simple(1'b0, OPC_BINARY, 1'b1, 2);
    send_simple(1'b0, OPC_PING, 1'b0, 1);
    send_simple(1'b1, OPC_CONT, 1'b1, 2);
    send_simple(1'b1, OPC_CONT, 1'b0, 1);
  endtask

  // Length equal to the limit passes; limit of zero allows only empty frames
  task automatic test_length_limit();
    write_limit(32'd5);
    send_simple(1'b1, OPC_TEXT, 1'b1, 5);
    write_limit(32'd0);
    send_simple(1'b0, OPC_TEXT, 1'b1, 0);
    send_simple(1'b1, OPC_CONT, 1'b0, 0);
    write_limit(32'hFFFF_FFFF);
    send_simple(1'b1, OPC_BINARY, 1'b0, 3);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input logic [31:0] limit, input int n_bytes);
    int stop_at;
    write_limit(limit);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) send_random_message();
    drain();
  endtask

  // Close or oversized frame, both halt the parser; later bytes are dropped
  task automatic test_halt();
    logic [31:0] len;
    send_idle_pct  = 22;
    recv_stall_pct = 22;
    if ($urandom_range(1)) begin
      halt_desc = "close frame";
      send_simple(1'b0, OPC_TEXT, 1'b1, 2);
      send_frame(1'b1, 3'($urandom), wsd_pkg::OPC_CLOSE, 1'($urandom), $urandom_range(127),
                 FORM_SHORT, '0, '0, 1'b0);
    end else begin
      halt_desc = "oversized frame";
      write_limit($urandom_range(100));
      send_simple(1'b0, OPC_BINARY, 1'b0, 0);
      len = limit_m + 1 + $urandom_range(50);
      send_frame(1'b1, 3'b000, OPC_CONT, 1'($urandom), len,
                 (len < 126) ? FORM_SHORT : FORM_EXT64, $urandom, '0, 1'b0);
    end
    for (int i = 0; i < 24; i++) push_byte($urandom_range(255));
    drain();
  endtask

  initial begin
    clear_deframer();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_frames();
    test_empty_frames();
    test_extended_lengths();
    test_fragmented_messages();
    test_length_limit();
    test_random_traffic(0, 0, 32'hFFFF_FFFF, RANDOM_BYTES);
    test_random_traffic(45, 0, wsd_pkg::MAX_LEN_RESET, RANDOM_BYTES);
    test_random_traffic(0, 45, $urandom_range(20, 300), RANDOM_BYTES);
    test_random_traffic(22, 22, 32'd64, RANDOM_BYTES);
    test_halt();

    $display("Covered %0d bytes in %0d frames, %0d results checked, four flow-control mixes",
             bytes_sent, frames_sent, results_seen);
    $display("Frame length limits from 0 to 2^32-1; run closed by a %s", halt_desc);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
